// ===== rtl/hsvrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types, constants and helpers shared by the HSV to RGB pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   localparam int unsigned HUE_WIDTH = 13;

   localparam logic [HUE_WIDTH-1:0] HUE_FULL_TURN  = 13'd5760;
   localparam logic [HUE_WIDTH-1:0] HUE_PER_SECTOR = 13'd960;

   // floor(rem * 256 / 960) == (rem * FRAC_RECIP) >> 16 for rem < 960
   localparam logic [14:0] FRAC_RECIP = 15'd17480;

   localparam logic [7:0] FULL_SCALE = 8'd255;

   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_WIDTH-1:0] hue;
      logic [7:0]           saturation;
      logic [7:0]           brightness;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // output of the fraction stages
   typedef struct packed {
      sector_type  sector;
      logic [7:0]  frac;
      logic [15:0] p_prod;
      logic [7:0]  saturation;
      logic [7:0]  brightness;
   } frac_type;

   // output of the scale stages
   typedef struct packed {
      sector_type  sector;
      logic [15:0] q_prod;
      logic [15:0] t_prod;
      logic [7:0]  p_val;
      logic [7:0]  brightness;
   } scale_type;

   // exact floor(y / 255) for y up to 255 * 255
   function automatic logic [7:0] div255(input logic [15:0] y);
      logic [16:0] sum;
      sum = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// ===== rtl/hsvrgb_frac.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_frac
// Hue wrap, sector split, sector fraction and the p product (two stages).
// ----------------------------------------------------------------------------
module hsvrgb_frac import hsvrgb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  req_type  in_data,
   output logic     out_valid,
   output frac_type out_data
);

   logic [HUE_WIDTH-1:0] hue_wrap;
   logic [HUE_WIDTH-1:0] sector_base;
   sector_type           sector_in;
   logic [9:0]           rem_in;

   logic                 s1_valid_ff;
   sector_type           s1_sector_ff;
   logic [9:0]           s1_rem_ff;
   logic [7:0]           s1_sat_ff;
   logic [7:0]           s1_bri_ff;

   logic [24:0]          frac_prod;
   frac_type             s2_in;
   logic                 s2_valid_ff;
   frac_type             s2_ff;

   always_comb begin
      hue_wrap = (in_data.hue >= HUE_FULL_TURN) ? in_data.hue - HUE_FULL_TURN : in_data.hue;
      if (hue_wrap < HUE_PER_SECTOR) begin
         sector_in   = SECTOR_RED;
         sector_base = '0;
      end else if (hue_wrap < 13'(2 * HUE_PER_SECTOR)) begin
         sector_in   = SECTOR_YELLOW;
         sector_base = HUE_PER_SECTOR;
      end else if (hue_wrap < 13'(3 * HUE_PER_SECTOR)) begin
         sector_in   = SECTOR_GREEN;
         sector_base = 13'(2 * HUE_PER_SECTOR);
      end else if (hue_wrap < 13'(4 * HUE_PER_SECTOR)) begin
         sector_in   = SECTOR_CYAN;
         sector_base = 13'(3 * HUE_PER_SECTOR);
      end else if (hue_wrap < 13'(5 * HUE_PER_SECTOR)) begin
         sector_in   = SECTOR_BLUE;
         sector_base = 13'(4 * HUE_PER_SECTOR);
      end else begin
         sector_in   = SECTOR_MAGENTA;
         sector_base = 13'(5 * HUE_PER_SECTOR);
      end
      rem_in = 10'(hue_wrap - sector_base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
      if (advance) begin
         s1_sector_ff <= sector_in;
         s1_rem_ff    <= rem_in;
         s1_sat_ff    <= in_data.saturation;
         s1_bri_ff    <= in_data.brightness;
      end
   end

   always_comb begin
      frac_prod         = {15'd0, s1_rem_ff} * {10'd0, FRAC_RECIP};
      s2_in.sector      = s1_sector_ff;
      s2_in.frac        = frac_prod[23:16];
      s2_in.p_prod      = s1_bri_ff * (FULL_SCALE - s1_sat_ff);
      s2_in.saturation  = s1_sat_ff;
      s2_in.brightness  = s1_bri_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_ff;

endmodule

// ===== rtl/hsvrgb_scale.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_scale
// Saturation weighting of the fraction and the brightness products (two stages).
// ----------------------------------------------------------------------------
module hsvrgb_scale import hsvrgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  frac_type  in_data,
   output logic      out_valid,
   output scale_type out_data
);

   logic [15:0] fq_prod;
   logic [16:0] ft_prod;
   logic [8:0]  frac_inv;
   logic [7:0]  kq_in;
   logic [7:0]  kt_in;
   logic [7:0]  p_in;

   logic        s3_valid_ff;
   sector_type  s3_sector_ff;
   logic [7:0]  s3_kq_ff;
   logic [7:0]  s3_kt_ff;
   logic [7:0]  s3_p_ff;
   logic [7:0]  s3_bri_ff;

   scale_type   s4_in;
   logic        s4_valid_ff;
   scale_type   s4_ff;

   always_comb begin
      frac_inv = 9'd256 - {1'b0, in_data.frac};
      fq_prod  = in_data.frac * in_data.saturation;
      ft_prod  = frac_inv * {1'b0, in_data.saturation};
      kq_in    = FULL_SCALE - fq_prod[15:8];
      kt_in    = FULL_SCALE - ft_prod[15:8];
      p_in     = div255(in_data.p_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= in_valid;
      end
      if (advance) begin
         s3_sector_ff <= in_data.sector;
         s3_kq_ff     <= kq_in;
         s3_kt_ff     <= kt_in;
         s3_p_ff      <= p_in;
         s3_bri_ff    <= in_data.brightness;
      end
   end

   always_comb begin
      s4_in.sector     = s3_sector_ff;
      s4_in.q_prod     = s3_bri_ff * s3_kq_ff;
      s4_in.t_prod     = s3_bri_ff * s3_kt_ff;
      s4_in.p_val      = s3_p_ff;
      s4_in.brightness = s3_bri_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_ff <= s4_in;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_data  = s4_ff;

endmodule

// ===== rtl/hsvrgb_mix.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Final scaling of q and t and the six-way sector select into the output register.
// ----------------------------------------------------------------------------
module hsvrgb_mix import hsvrgb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      advance,
   input  logic      in_valid,
   input  scale_type in_data,
   output logic      out_valid,
   output rsp_type   out_data
);

   logic [7:0] q_val;
   logic [7:0] t_val;
   logic [7:0] v_val;
   logic [7:0] p_val;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;

   always_comb begin
      q_val = div255(in_data.q_prod);
      t_val = div255(in_data.t_prod);
      v_val = in_data.brightness;
      p_val = in_data.p_val;
      case (in_data.sector)
         SECTOR_RED: begin
            rsp_in = '{red: v_val, green: t_val, blue: p_val};
         end
         SECTOR_YELLOW: begin
            rsp_in = '{red: q_val, green: v_val, blue: p_val};
         end
         SECTOR_GREEN: begin
            rsp_in = '{red: p_val, green: v_val, blue: t_val};
         end
         SECTOR_CYAN: begin
            rsp_in = '{red: p_val, green: q_val, blue: v_val};
         end
         SECTOR_BLUE: begin
            rsp_in = '{red: t_val, green: p_val, blue: v_val};
         end
         default: begin
            rsp_in = '{red: v_val, green: p_val, blue: q_val};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== rtl/hsv_to_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// hsv_to_rgb_unit
// HSV to RGB pixel converter, five-stage pipeline.
// ----------------------------------------------------------------------------
// A request on req_* carries hue in sixteenths of a degree plus 8-bit
// saturation and brightness; each request gives exactly one rsp_* result
// with 8-bit red, green and blue. A request is taken on a clock edge where
// req_valid is high and req_stall is low; a result leaves the same way on
// rsp_valid / rsp_stall.
// One request is accepted every cycle while the pipeline is not stalled:
// the five stage registers (sector split, fraction and p product,
// saturation weights, brightness products, final scale and select) each
// hold a different pixel.
// When the receiver stalls a waiting result, the whole pipeline holds and
// req_stall goes high in the same cycle; nothing is dropped or repeated.
// Bubbles stay in place, so the request side sees back-pressure only while
// a result is actually waiting.
// Reset clears all valid bits; no result is shown until new requests arrive.
// ----------------------------------------------------------------------------
module hsv_to_rgb_unit import hsvrgb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic      advance;
   logic      frac_valid;
   frac_type  frac_data;
   logic      scale_valid;
   scale_type scale_data;

   // hold everything while a finished result waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   hsvrgb_frac u_frac (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (frac_valid),
      .out_data  (frac_data)
   );

   hsvrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (frac_valid),
      .in_data   (frac_data),
      .out_valid (scale_valid),
      .out_data  (scale_data)
   );

   hsvrgb_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (scale_valid),
      .in_data   (scale_data),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule

// ===== rtl/hsvrgb_checker.sv =====
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks for hsv_to_rgb_unit, attached by bind.
// ----------------------------------------------------------------------------
module hsvrgb_checker import hsvrgb_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // back-pressure only while a result is waiting
   assert property (@(posedge clock) req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a waiting result");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // a request reaches the output once it has moved through every stage register
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !req_stall ##1 !req_stall ##1 !req_stall
      ##1 !req_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

   // zero saturation gives a grey pixel
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.saturation == 8'd0) ##1 !req_stall
      ##1 !req_stall ##1 !req_stall ##1 !req_stall
      |=> (rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue))
      else $error("grey input did not give a grey pixel");

endmodule

bind hsv_to_rgb_unit hsvrgb_checker u_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for hsv_to_rgb_unit. Directed corner pixels and then random
// pixels are sent over the request channel. A predictor computes the
// expected RGB triple for each accepted request, and each result is checked
// in order against it. Both channels idle and stall at random. One phase
// runs with no idling at all, and one phase holds the output off long
// enough to fill the pipeline and back-pressure the request side.
// ----------------------------------------------------------------------------
module tb_top import hsvrgb_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned REPORT_LIMIT    = 10;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   rsp_type     expected_rgb[$];
   bit          idle_on = 1'b1;
   int unsigned hold_off_left = 0;
   int unsigned mismatches = 0;
   int unsigned pixels_checked = 0;
   int unsigned wrapped_hues = 0;
   int unsigned grey_pixels = 0;
   int unsigned input_stall_cycles = 0;

   hsv_to_rgb_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("hsv_to_rgb_unit verification failed");
      $finish;
   end

   function automatic rsp_type hsv_predict(input req_type px);
      int unsigned angle, sector_idx, offset, frac, s, v, p, q, t, r, g, b;
      sector_type  sector;
      rsp_type     rgb;
      angle = 32'(px.hue);
      s     = 32'(px.saturation);
      v     = 32'(px.brightness);
      // hue past a full turn wraps back once
      if (angle >= 32'(HUE_FULL_TURN)) begin
         angle = angle - 32'(HUE_FULL_TURN);
      end
      sector_idx = angle / 32'(HUE_PER_SECTOR);
      offset     = angle % 32'(HUE_PER_SECTOR);
      frac       = (offset * 256) / 32'(HUE_PER_SECTOR);
      sector     = sector_type'(sector_idx[2:0]);
      p = (v * (255 - s)) / 255;
      q = (v * (255 - ((frac * s) >> 8))) / 255;
      t = (v * (255 - (((256 - frac) * s) >> 8))) / 255;
      case (sector)
         SECTOR_RED: begin
            r = v; g = t; b = p;
         end
         SECTOR_YELLOW: begin
            r = q; g = v; b = p;
         end
         SECTOR_GREEN: begin
            r = p; g = v; b = t;
         end
         SECTOR_CYAN: begin
            r = p; g = q; b = v;
         end
         SECTOR_BLUE: begin
            r = t; g = p; b = v;
         end
         default: begin
            r = v; g = p; b = q;
         end
      endcase
      rgb.red   = r[7:0];
      rgb.green = g[7:0];
      rgb.blue  = b[7:0];
      return rgb;
   endfunction

   function automatic req_type make_pixel(input int unsigned hue, input int unsigned sat,
                                          input int unsigned val);
      req_type px;
      px.hue        = hue[12:0];
      px.saturation = sat[7:0];
      px.brightness = val[7:0];
      return px;
   endfunction

   function automatic req_type random_pixel();
      int unsigned hue, sat, val, pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         hue = $urandom_range(8191, 5760);
      end else begin
         hue = $urandom_range(5759, 0);
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
         sat = 0;
      end else if (pick < 24) begin
         sat = 255;
      end else begin
         sat = $urandom_range(255, 0);
      end
      pick = $urandom_range(99);
      if (pick < 12) begin
         val = 0;
      end else if (pick < 24) begin
         val = 255;
      end else begin
         val = $urandom_range(255, 0);
      end
      return make_pixel(hue, sat, val);
   endfunction

   // receiver side: a counted hold-off wins over random stalls
   always @(posedge clock) begin
      if (hold_off_left != 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (idle_on) begin
         rsp_stall <= ($urandom_range(99) < 20);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // check results against the oldest prediction, then predict new requests
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rgb.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: result with no request pending: r=%0d g=%0d b=%0d",
                           $realtime, rsp_data.red, rsp_data.green, rsp_data.blue);
               end
            end else begin
               want = expected_rgb.pop_front();
               pixels_checked++;
               if (rsp_data.red !== want.red || rsp_data.green !== want.green ||
                   rsp_data.blue !== want.blue) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: rgb mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                              $realtime, want.red, want.green, want.blue,
                              rsp_data.red, rsp_data.green, rsp_data.blue);
                  end
               end
            end
         end
         if (req_valid && req_stall) begin
            input_stall_cycles++;
         end
         if (req_valid && !req_stall) begin
            expected_rgb.push_back(hsv_predict(req_data));
            if (req_data.hue >= HUE_FULL_TURN) begin
               wrapped_hues++;
            end
            if (req_data.saturation == 8'd0) begin
               grey_pixels++;
            end
         end
      end
   end

   task automatic send_pixel(input req_type px);
      int unsigned gap;
      if (idle_on && $urandom_range(99) < 20) begin
         gap = $urandom_range(3, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic test_sector_corners();
      // sector starts, where the fraction is zero
      send_pixel(make_pixel(0, 255, 255));
      send_pixel(make_pixel(960, 255, 255));
      send_pixel(make_pixel(1920, 255, 255));
      send_pixel(make_pixel(2880, 255, 255));
      send_pixel(make_pixel(3840, 200, 180));
      send_pixel(make_pixel(4800, 255, 255));
      // first and last steps of a sector and the largest in-range hue
      send_pixel(make_pixel(1, 255, 255));
      send_pixel(make_pixel(959, 255, 255));
      send_pixel(make_pixel(2879, 170, 99));
      send_pixel(make_pixel(5759, 255, 255));
      // hues past a full turn
      send_pixel(make_pixel(5760, 255, 255));
      send_pixel(make_pixel(6720, 200, 180));
      send_pixel(make_pixel(7777, 128, 255));
      send_pixel(make_pixel(8191, 255, 255));
      // grey and black, then two coloured pixels
      send_pixel(make_pixel(480, 0, 200));
      send_pixel(make_pixel(3000, 0, 255));
      send_pixel(make_pixel(2000, 255, 0));
      send_pixel(make_pixel(0, 0, 0));
      send_pixel(make_pixel(1234, 128, 255));
      send_pixel(make_pixel(4321, 1, 254));
   endtask

   task automatic test_random_pixels(input int unsigned count);
      idle_on = 1'b1;
      repeat (count) send_pixel(random_pixel());
   endtask

   task automatic test_streaming(input int unsigned count);
      idle_on = 1'b0;
      repeat (count) send_pixel(random_pixel());
      idle_on = 1'b1;
   endtask

   task automatic test_output_hold_off();
      idle_on = 1'b0;
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (40) send_pixel(random_pixel());
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_sector_corners();
      test_random_pixels(700);
      test_streaming(300);
      test_output_hold_off();
      test_random_pixels(300);
      req_valid <= 1'b0;
      while (expected_rgb.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      $display("checked %0d pixels over all six sectors: %0d past a full turn, %0d grey",
               pixels_checked, wrapped_hues, grey_pixels);
      $display("request side saw back-pressure in %0d cycles", input_stall_cycles);
      if (mismatches == 0 && expected_rgb.size() == 0) begin
         $display("hsv_to_rgb_unit verification clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("hsv_to_rgb_unit verification failed");
      end
      $finish;
   end

endmodule
